[rtl/dhs_pkg.sv]
package dhs_pkg;

	localparam int BUCKETS  = 256;
	localparam int WAYS     = 4;
	localparam int SLOTS    = BUCKETS * WAYS;
	localparam int BUCKET_W = $clog2(BUCKETS);
	localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int HALF_W   = 64;
	localparam int KEY_W    = 2 * HALF_W;
	localparam int ENTRY_W  = 11;
	localparam int TOTAL_W  = $clog2(SLOTS + 1);
	localparam int CNT_W    = (TOTAL_W > ENTRY_W) ? TOTAL_W : ENTRY_W;

	typedef enum logic [1:0] {
		ACT_CONTAINS = 2'd0,
		ACT_INSERT   = 2'd1,
		ACT_REMOVE   = 2'd2,
		ACT_CLEAN    = 2'd3
	} action_t;

	typedef struct packed {
		logic [1:0]        action;
		logic [HALF_W-1:0] digest_high;
		logic [HALF_W-1:0] digest_low;
	} req_t;

	typedef struct packed {
		logic               success;
		logic               bucket_full;
		logic [ENTRY_W-1:0] entry_count;
		logic               dirty_flag;
	} rsp_t;

	// Control from the sequencer to the shared key comparator.
	typedef struct packed {
		logic             clr;
		logic             en;
		logic             way_ok;
		logic [WAY_W-1:0] way;
	} probe_ctl_t;

	typedef struct packed {
		logic             hit;
		logic [WAY_W-1:0] way;
	} probe_res_t;

	function automatic logic [SLOT_W-1:0] slot_addr(input logic [BUCKET_W-1:0] bucket,
		input logic [WAY_W-1:0] way);
		slot_addr = SLOT_W'(bucket) * SLOT_W'(WAYS) + SLOT_W'(way);
	endfunction

endpackage

[rtl/digest_hash_set.sv]
// Channel | Signals                   | Direction | Beat content
// --------+---------------------------+-----------+--------------------------------------
// req     | req_valid, req_stall, req | in        | action, digest_high, digest_low
// rsp     | rsp_valid, rsp_stall, rsp | out       | success, bucket_full, entry_count, dirty
//
// Each request runs through a read of the bucket's way mask, a compare of every way in
// turn through the single shared 128-bit key comparator, the commit and a return to idle,
// where the next beat lands; no new request is taken before the last one is committed.
// The result beat is registered at the commit, once the last way has been compared.
// Reset clears the per-bucket row valid bits, the entry count and the dirty flag at once;
// the key memory itself is never cleared and needs no clearing pass.
// A stalled result beat holds; a new request is still taken while it waits, and the commit
// of that request waits until the output register is free.
module digest_hash_set (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  dhs_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output dhs_pkg::rsp_t rsp
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MASK = 4'b0010,
		S_CMP  = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q;

	// Captured request and bucket under work.
	dhs_pkg::req_t                req_q;
	logic [dhs_pkg::BUCKET_W-1:0] bucket;

	// Way mask of the bucket, one bit per occupied way.
	logic [dhs_pkg::WAYS-1:0]     mask_q;
	logic [dhs_pkg::WAY_W-1:0]    way_q;
	logic                         last_way;

	// A bucket row that was never written reads as all ways free.
	logic [dhs_pkg::BUCKETS-1:0]  row_vld_q;

	logic [dhs_pkg::CNT_W-1:0]    cnt_q;
	logic                         dirty_q;

	dhs_pkg::rsp_t                rsp_q;
	logic                         rsp_valid_q;

	// Memory ports.
	logic [dhs_pkg::BUCKET_W-1:0] mask_rd_addr;
	logic [dhs_pkg::WAYS-1:0]     mask_rd_data;
	logic                         mask_we;
	logic [dhs_pkg::WAYS-1:0]     mask_wr_data;
	logic [dhs_pkg::SLOT_W-1:0]   key_rd_addr;
	logic [dhs_pkg::KEY_W-1:0]    key_rd_data;
	logic                         key_we;
	logic [dhs_pkg::SLOT_W-1:0]   key_wr_addr;

	dhs_pkg::probe_ctl_t          probe_ctl;
	dhs_pkg::probe_res_t          probe_res;

	// Commit decisions.
	logic                         free_found;
	logic [dhs_pkg::WAY_W-1:0]    free_way;
	logic                         commit;
	logic                         do_insert;
	logic                         do_remove;
	logic                         res_ok;
	logic                         res_full;
	logic [dhs_pkg::CNT_W-1:0]    cnt_next;
	logic                         dirty_next;

	assign bucket   = req_q.digest_high[dhs_pkg::HALF_W-1 -: dhs_pkg::BUCKET_W];
	assign last_way = (way_q == dhs_pkg::WAY_W'(dhs_pkg::WAYS - 1));

	// New requests land only while the sequencer is idle.
	assign req_stall = (state_q != S_IDLE);

	// The commit happens once the output register has room for the result.
	assign commit = (state_q == S_DONE) && (!rsp_valid_q || !rsp_stall);

	// The mask read is issued in the accept cycle so it is ready in S_MASK.
	assign mask_rd_addr = (state_q == S_IDLE) ?
		req.digest_high[dhs_pkg::HALF_W-1 -: dhs_pkg::BUCKET_W] : bucket;

	// Key reads run one way ahead of the comparator.
	always_comb begin
		if (state_q == S_MASK) begin
			key_rd_addr = dhs_pkg::slot_addr(bucket, '0);
		end else if (last_way) begin
			key_rd_addr = dhs_pkg::slot_addr(bucket, way_q);
		end else begin
			key_rd_addr = dhs_pkg::slot_addr(bucket, way_q + dhs_pkg::WAY_W'(1));
		end
	end

	assign probe_ctl.clr    = (state_q == S_MASK);
	assign probe_ctl.en     = (state_q == S_CMP);
	assign probe_ctl.way_ok = mask_q[way_q];
	assign probe_ctl.way    = way_q;

	dhs_probe u_probe (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (probe_ctl),
		.key_ref ({req_q.digest_high, req_q.digest_low}),
		.key_rd  (key_rd_data),
		.res     (probe_res)
	);

	// Lowest-numbered free way of the bucket.
	always_comb begin
		free_found = 1'b0;
		free_way   = '0;
		for (int i = dhs_pkg::WAYS - 1; i >= 0; i--) begin
			if (!mask_q[i]) begin
				free_found = 1'b1;
				free_way   = dhs_pkg::WAY_W'(i);
			end
		end
	end

	always_comb begin
		do_insert  = 1'b0;
		do_remove  = 1'b0;
		res_ok     = 1'b0;
		res_full   = 1'b0;
		cnt_next   = cnt_q;
		dirty_next = dirty_q;
		unique case (dhs_pkg::action_t'(req_q.action))
			dhs_pkg::ACT_CONTAINS: begin
				res_ok = probe_res.hit;
			end
			dhs_pkg::ACT_INSERT: begin
				// A digest already present is refused without touching the bucket.
				if (!probe_res.hit) begin
					if (free_found) begin
						do_insert  = 1'b1;
						res_ok     = 1'b1;
						cnt_next   = cnt_q + dhs_pkg::CNT_W'(1);
						dirty_next = 1'b1;
					end else begin
						res_full = 1'b1;
					end
				end
			end
			dhs_pkg::ACT_REMOVE: begin
				if (probe_res.hit) begin
					do_remove  = 1'b1;
					res_ok     = 1'b1;
					dirty_next = 1'b1;
					if (cnt_q != '0) begin
						cnt_next = cnt_q - dhs_pkg::CNT_W'(1);
					end
				end
			end
			dhs_pkg::ACT_CLEAN: begin
				res_ok     = 1'b1;
				dirty_next = 1'b0;
			end
			default: begin
				res_ok = 1'b0;
			end
		endcase
	end

	assign mask_we      = commit && (do_insert || do_remove);
	assign mask_wr_data = do_insert ?
		(mask_q | (dhs_pkg::WAYS'(1) << free_way)) :
		(mask_q & ~(dhs_pkg::WAYS'(1) << probe_res.way));

	assign key_we      = commit && do_insert;
	assign key_wr_addr = dhs_pkg::slot_addr(bucket, free_way);

	dhs_ram #(
		.WIDTH (dhs_pkg::WAYS),
		.DEPTH (dhs_pkg::BUCKETS)
	) u_mask_ram (
		.clk     (clk),
		.wr_en   (mask_we),
		.wr_addr (bucket),
		.wr_data (mask_wr_data),
		.rd_addr (mask_rd_addr),
		.rd_data (mask_rd_data)
	);

	dhs_ram #(
		.WIDTH (dhs_pkg::KEY_W),
		.DEPTH (dhs_pkg::SLOTS)
	) u_key_ram (
		.clk     (clk),
		.wr_en   (key_we),
		.wr_addr (key_wr_addr),
		.wr_data ({req_q.digest_high, req_q.digest_low}),
		.rd_addr (key_rd_addr),
		.rd_data (key_rd_data)
	);

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			row_vld_q   <= '0;
			cnt_q       <= '0;
			dirty_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			// A commit loads a new result beat; otherwise an accepted beat empties the register.
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_MASK;
					end
				end
				S_MASK: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (last_way) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (commit) begin
						state_q     <= S_IDLE;
						cnt_q       <= cnt_next;
						dirty_q     <= dirty_next;
						if (mask_we) begin
							row_vld_q[bucket] <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			req_q <= req;
		end
		if (state_q == S_MASK) begin
			mask_q <= row_vld_q[bucket] ? mask_rd_data : '0;
			way_q  <= '0;
		end else if (state_q == S_CMP && !last_way) begin
			way_q <= way_q + dhs_pkg::WAY_W'(1);
		end
		if (commit) begin
			rsp_q.success     <= res_ok;
			rsp_q.bucket_full <= res_full;
			rsp_q.entry_count <= cnt_next[dhs_pkg::ENTRY_W-1:0];
			rsp_q.dirty_flag  <= dirty_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[rtl/dhs_ram.sv]
module dhs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

[rtl/dhs_probe.sv]
module dhs_probe (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dhs_pkg::probe_ctl_t       ctl,
	input  logic [dhs_pkg::KEY_W-1:0] key_ref,
	input  logic [dhs_pkg::KEY_W-1:0] key_rd,
	output dhs_pkg::probe_res_t       res
);

	logic                      hit_q;
	logic [dhs_pkg::WAY_W-1:0] way_q;
	logic                      match;

	// One full-width compare, reused for every way of the bucket.
	assign match = ctl.way_ok && (key_rd == key_ref);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.clr) begin
			hit_q <= 1'b0;
		end else if (ctl.en && match && !hit_q) begin
			hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en && match && !hit_q) begin
			way_q <= ctl.way;
		end
	end

	assign res.hit = hit_q;
	assign res.way = way_q;

endmodule

[rtl/dhs_checker.sv]
module dhs_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input dhs_pkg::rsp_t rsp
);

	// A stalled result beat holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result beat changed while stalled");

	// Once a request is accepted, the block stalls its request side.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while the previous one was in progress");

	// A new result only appears when a request was in progress.
	a_rsp_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("result beat without a request in progress");

	// A refused insert never reports success.
	a_full_not_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.success && rsp.bucket_full))
		else $error("bucket full reported together with success");

endmodule

bind digest_hash_set dhs_checker u_dhs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

[tb/tb_digest_hash_set.sv]
module tb_digest_hash_set;
	timeunit 1ns;
	timeprecision 1ps;

	import dhs_pkg::*;

	// Run shape. The hold-off starts once HOLD_AT result beats have been checked.
	localparam int HOLD_AT      = 150;
	localparam int HOLD_CYCLES  = 400;
	localparam int MIXED_ITEMS  = 500;
	localparam int LATE_ITEMS   = 300;
	localparam int TAIL_CYCLES  = 20;
	// The longest correct stretch without any beat is the hold-off plus a sender gap and the
	// time to work one request, so this limit leaves a wide margin.
	localparam int STUCK_LIMIT  = 4000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	always #5 clk = ~clk;

	digest_hash_set DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// Request beats waiting to be offered, and the results that accepted requests owe us.
	req_t request_queue[$];
	rsp_t outcome_queue[$];
	// Every digest that was ever offered for insertion; later actions pick from it so
	// that lookups and removals mostly hit.
	logic [KEY_W-1:0] key_pool[$];

	// Shadow of the set: keys, way valid bits, the total and the dirty flag.
	logic [HALF_W-1:0] shadow_high[SLOTS];
	logic [HALF_W-1:0] shadow_low[SLOTS];
	bit                shadow_used[SLOTS];
	int                shadow_total = 0;
	bit                shadow_dirty = 1'b0;

	// Statistics for the closing summary.
	int beats_sent = 0;
	int inserts_done = 0;
	int removes_done = 0;
	int full_refusals = 0;
	int peak_total = 0;

	int  errors = 0;
	int  beats_checked = 0;
	int  idle_cycles = 0;
	bit  timed_out = 1'b0;

	// Applies one request to the shadow set and returns the result beat it must produce.
	// The bucket is the digest's first byte; a hit needs all 128 bits to match, and an
	// insert takes the lowest-numbered free way of the bucket.
	function automatic rsp_t apply_action(input req_t beat);
		rsp_t out;
		int   base;
		int   hit_way;
		int   free_way;
		base = (int'(beat.digest_high[HALF_W-1 -: 8]) % BUCKETS) * WAYS;
		hit_way = -1;
		free_way = -1;
		out = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (shadow_used[base + w] && shadow_high[base + w] == beat.digest_high &&
				shadow_low[base + w] == beat.digest_low && hit_way < 0)
				hit_way = w;
			if (!shadow_used[base + w] && free_way < 0)
				free_way = w;
		end
		case (beat.action)
			ACT_CONTAINS: begin
				out.success = (hit_way >= 0);
			end
			ACT_INSERT: begin
				// A digest already present is refused quietly, even in a full bucket.
				if (hit_way < 0) begin
					if (free_way < 0) begin
						out.bucket_full = 1'b1;
						full_refusals++;
					end else begin
						shadow_high[base + free_way] = beat.digest_high;
						shadow_low[base + free_way] = beat.digest_low;
						shadow_used[base + free_way] = 1'b1;
						shadow_total++;
						shadow_dirty = 1'b1;
						out.success = 1'b1;
						inserts_done++;
					end
				end
			end
			ACT_REMOVE: begin
				if (hit_way >= 0) begin
					shadow_used[base + hit_way] = 1'b0;
					if (shadow_total > 0)
						shadow_total--;
					shadow_dirty = 1'b1;
					out.success = 1'b1;
					removes_done++;
				end
			end
			default: begin
				// Mark clean never touches the keys; it only drops the dirty flag.
				shadow_dirty = 1'b0;
				out.success = 1'b1;
			end
		endcase
		if (shadow_total > peak_total)
			peak_total = shadow_total;
		out.entry_count = ENTRY_W'(shadow_total);
		out.dirty_flag = shadow_dirty;
		return out;
	endfunction

	task automatic check_field(input string name, input int want, input logic [15:0] got);
		if (got !== want[15:0]) begin
			$display("%0t: mismatch in %s, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// A fresh digest whose first byte, and so its bucket, is chosen by the caller.
	function automatic logic [KEY_W-1:0] fresh_digest(input logic [7:0] lead);
		logic [31:0] w0, w1, w2, w3;
		w0 = $urandom();
		w1 = $urandom();
		w2 = $urandom();
		w3 = $urandom();
		return {lead, w0[23:0], w1, w2, w3};
	endfunction

	task automatic queue_item(input action_t act, input logic [KEY_W-1:0] key);
		req_t beat;
		beat.action = act;
		beat.digest_high = key[KEY_W-1:HALF_W];
		beat.digest_low = key[HALF_W-1:0];
		request_queue.push_back(beat);
		if (act == ACT_INSERT)
			key_pool.push_back(key);
	endtask

	// One random action. Most reuse known digests so that hits, removals and duplicate
	// inserts are common; some are near misses that share the bucket and all but one bit;
	// a few are pure noise. With hot set, new digests crowd a handful of buckets so that
	// they fill up and start refusing inserts.
	task automatic random_item(input bit hot);
		logic [7:0]       hot_leads[6];
		logic [KEY_W-1:0] key;
		action_t          act;
		int               sel;
		int               pick;
		hot_leads = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h80, 8'h01};
		sel = $urandom_range(0, 99);
		if (sel < 35)
			act = ACT_INSERT;
		else if (sel < 60)
			act = ACT_REMOVE;
		else if (sel < 92)
			act = ACT_CONTAINS;
		else
			act = ACT_CLEAN;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			act = action_t'($urandom_range(0, 3));
			key = fresh_digest(8'($urandom()));
		end else if (pick < 60 && key_pool.size() > 0) begin
			key = key_pool[$urandom_range(0, key_pool.size() - 1)];
		end else if (pick < 80 && key_pool.size() > 0) begin
			key = key_pool[$urandom_range(0, key_pool.size() - 1)];
			key[$urandom_range(0, KEY_W - 9)] ^= 1'b1;
		end else if (hot && $urandom_range(0, 9) < 7) begin
			key = fresh_digest(hot_leads[$urandom_range(0, 5)]);
		end else begin
			key = fresh_digest(8'($urandom()));
		end
		queue_item(act, key);
	endtask

	// Holds the sender back until every offered beat has been answered.
	task automatic wait_drained();
		do
			@(posedge clk);
		while (request_queue.size() != 0 || req_valid || outcome_queue.size() != 0);
	endtask

	task automatic run_stimulus();
		logic [KEY_W-1:0] k_zero, k_ones, k_b0a, k_b0b, k_b0c, k_spill;
		k_zero = '0;
		k_ones = '1;
		k_b0a = {{HALF_W{1'b0}}, {HALF_W{1'b1}}};
		k_b0b = {8'h00, {(HALF_W - 8){1'b1}}, {HALF_W{1'b0}}};
		k_b0c = fresh_digest(8'h00);
		k_spill = fresh_digest(8'h00);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: lookups on an empty set, duplicates, a bucket driven full, reuse of
		// a freed way, removal of absent digests, and mark clean before and after changes.
		queue_item(ACT_CONTAINS, k_zero);
		queue_item(ACT_INSERT, k_zero);
		queue_item(ACT_INSERT, k_zero);
		queue_item(ACT_CONTAINS, k_zero);
		queue_item(ACT_CLEAN, k_zero);
		queue_item(ACT_INSERT, k_ones);
		queue_item(ACT_INSERT, k_b0a);
		queue_item(ACT_INSERT, k_b0b);
		queue_item(ACT_INSERT, k_b0c);
		queue_item(ACT_INSERT, k_spill);
		queue_item(ACT_INSERT, k_zero);
		queue_item(ACT_CONTAINS, k_spill);
		queue_item(ACT_REMOVE, fresh_digest(8'h00));
		queue_item(ACT_REMOVE, k_zero);
		queue_item(ACT_CONTAINS, k_zero);
		queue_item(ACT_INSERT, k_spill);
		queue_item(ACT_CONTAINS, k_spill);
		queue_item(ACT_REMOVE, k_ones);
		queue_item(ACT_CONTAINS, k_ones);
		queue_item(ACT_CLEAN, k_ones);
		queue_item(ACT_REMOVE, k_ones);
		queue_item(ACT_CONTAINS, {k_ones[KEY_W-1:HALF_W], {HALF_W{1'b0}}});
		queue_item(ACT_CLEAN, k_zero);
		queue_item(ACT_CLEAN, k_zero);
		wait_drained();

		// Mixed traffic on a few crowded buckets. The receiver's long hold-off falls here.
		repeat (MIXED_ITEMS) random_item(1'b1);
		wait_drained();

		// Four new digests into every bucket: whatever was there already, the table ends
		// up completely full and the entry count reaches SLOTS, 1024.
		for (int b = 0; b < BUCKETS; b++)
			repeat (WAYS) queue_item(ACT_INSERT, fresh_digest(8'(b)));
		wait_drained();

		// Mixed traffic on a nearly full table, spread over all buckets.
		repeat (LATE_ITEMS) random_item(1'b0);
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// Sender: bursts of random length separated by random gaps, sometimes none at all.
	// A beat stays on the bus until it is accepted.
	int gap_left = 0;
	int burst_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			gap_left = 0;
			burst_left = 0;
		end else begin
			if (req_valid && !req_stall) begin
				outcome_queue.push_back(apply_action(req));
				beats_sent++;
			end
			if (!req_valid || !req_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else if (request_queue.size() > 0) begin
					req <= request_queue.pop_front();
					req_valid <= 1'b1;
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks every result beat against the oldest expectation and drives the
	// stall. The stall pattern is redrawn at random among no stall, light and heavy random
	// stalling, and a fixed duty cycle. Once, after HOLD_AT result beats, it holds the stall
	// high so that the block backs up and stalls its request side.
	int       stall_mode = 0;
	int       cycle_count = 0;
	int       hold_left = 0;
	bit       hold_done = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			idle_cycles <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (outcome_queue.size() == 0) begin
					$display("%0t: result beat with no request waiting, actual %p", $time, rsp);
					errors++;
				end else begin
					rsp_t want;
					want = outcome_queue.pop_front();
					check_field("success", want.success, rsp.success);
					check_field("bucket_full", want.bucket_full, rsp.bucket_full);
					check_field("entry_count", want.entry_count, rsp.entry_count);
					check_field("dirty_flag", want.dirty_flag, rsp.dirty_flag);
				end
				beats_checked <= beats_checked + 1;
			end
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;

			cycle_count++;
			if (cycle_count % 256 == 0)
				stall_mode = $urandom_range(0, 3);
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else if (!hold_done && beats_checked == HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				rsp_stall <= 1'b1;
			end else begin
				case (stall_mode)
					0: rsp_stall <= 1'b0;
					1: rsp_stall <= ($urandom_range(0, 3) == 0);
					2: rsp_stall <= ($urandom_range(0, 3) != 0);
					default: rsp_stall <= (cycle_count % 8 < 5);
				endcase
			end
		end
	end

	initial begin
		fork
			run_stimulus();
			begin
				while (idle_cycles < STUCK_LIMIT)
					@(posedge clk);
				timed_out = 1'b1;
				$display("%0t: no beat accepted for %0d cycles, giving up", $time, STUCK_LIMIT);
			end
		join_any
		disable fork;
		if (outcome_queue.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, outcome_queue.size());
			errors++;
		end
		$display("Sent %0d requests, checked %0d results, %0d mismatches.",
			beats_sent, beats_checked, errors);
		$display("Inserted %0d, removed %0d, refused %0d on full buckets, peak count %0d.",
			inserts_done, removes_done, full_refusals, peak_total);
		if (!timed_out && errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
